// ===== rtl/alle_pkg.sv =====
// Shared types, codes and the control store for the array linked list engine.
// Used by alle_seq, alle_dp and array_linked_list_engine_unit; depends on nothing.
package alle_pkg;

	localparam int DEF_SLOT_COUNT = 1024;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int POS_W = 10;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		MD_INS_AFTER  = 2'd0,
		MD_INS_BEFORE = 2'd1,
		MD_DEL_AFTER  = 2'd2,
		MD_DEL_BEFORE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		mode_t                   mode;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] slot;
		status_t          status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'd0,
		S_CHK  = 4'd1,
		S_INA1 = 4'd2,
		S_INA2 = 4'd3,
		S_INB1 = 4'd4,
		S_INB2 = 4'd5,
		S_DLA1 = 4'd6,
		S_DLB1 = 4'd7,
		S_DEL2 = 4'd8,
		S_DEL3 = 4'd9,
		S_FIN  = 4'd10
	} step_t;

	// operand sources for link memory write address and data
	typedef enum logic [2:0] {
		SRC_POS  = 3'd0,  // position of the request
		SRC_D    = 3'd1,  // slot being inserted or removed
		SRC_LNK  = 3'd2,  // neighbor of position on the op's side
		SRC_FH   = 3'd3,  // free head
		SRC_FREL = 3'd4,  // prev for a released slot
		SRC_FARN = 3'd5,  // next of removed slot
		SRC_FARP = 3'd6   // prev of removed slot
	} src_t;

	typedef enum logic {
		RA_POS  = 1'b0,
		RA_LINK = 1'b1
	} ra_t;

	typedef enum logic [1:0] {
		FH_KEEP = 2'd0,
		FH_NF   = 2'd1,
		FH_D    = 2'd2
	} fh_t;

	typedef enum logic [1:0] {
		J_GOTO     = 2'd0,
		J_WAIT     = 2'd1,
		J_DISPATCH = 2'd2
	} jmp_t;

	typedef struct packed {
		ra_t   ra_sel;
		logic  rda_en;
		logic  rdb_en;
		logic  ld_chk;
		logic  nw_en;
		src_t  nw_addr;
		src_t  nw_data;
		logic  pw_en;
		logic  pw_fhnz;
		src_t  pw_addr;
		src_t  pw_data;
		logic  uw_en;
		logic  uw_val;
		logic  dw_en;
		fh_t   fh_ld;
		logic  emit;
		jmp_t  jmp;
		step_t tgt;
	} cw_t;

	typedef struct packed {
		logic  ok;
		mode_t mode;
	} dpf_t;

	localparam cw_t CW_NOP = '{
		ra_sel: RA_POS, rda_en: 1'b0, rdb_en: 1'b0, ld_chk: 1'b0,
		nw_en: 1'b0, nw_addr: SRC_POS, nw_data: SRC_POS,
		pw_en: 1'b0, pw_fhnz: 1'b0, pw_addr: SRC_POS, pw_data: SRC_POS,
		uw_en: 1'b0, uw_val: 1'b0, dw_en: 1'b0, fh_ld: FH_KEEP,
		emit: 1'b0, jmp: J_GOTO, tgt: S_IDLE
	};

	// control store: one word per step
	function automatic cw_t ucode(step_t s);
		cw_t c;
		c = CW_NOP;
		unique case (s)
			S_IDLE: begin
				c.ra_sel = RA_POS;
				c.rda_en = 1'b1;
				c.rdb_en = 1'b1;
				c.jmp    = J_WAIT;
				c.tgt    = S_CHK;
			end
			S_CHK: begin
				c.ra_sel = RA_LINK;
				c.rda_en = 1'b1;
				c.ld_chk = 1'b1;
				c.jmp    = J_DISPATCH;
			end
			S_INA1: begin
				c.nw_en   = 1'b1;
				c.nw_addr = SRC_D;
				c.nw_data = SRC_LNK;
				c.pw_en   = 1'b1;
				c.pw_addr = SRC_D;
				c.pw_data = SRC_POS;
				c.tgt     = S_INA2;
			end
			S_INA2: begin
				c.pw_en   = 1'b1;
				c.pw_addr = SRC_LNK;
				c.pw_data = SRC_D;
				c.nw_en   = 1'b1;
				c.nw_addr = SRC_POS;
				c.nw_data = SRC_D;
				c.fh_ld   = FH_NF;
				c.uw_en   = 1'b1;
				c.uw_val  = 1'b1;
				c.dw_en   = 1'b1;
				c.emit    = 1'b1;
				c.tgt     = S_IDLE;
			end
			S_INB1: begin
				c.pw_en   = 1'b1;
				c.pw_addr = SRC_D;
				c.pw_data = SRC_LNK;
				c.nw_en   = 1'b1;
				c.nw_addr = SRC_D;
				c.nw_data = SRC_POS;
				c.tgt     = S_INB2;
			end
			S_INB2: begin
				c.nw_en   = 1'b1;
				c.nw_addr = SRC_LNK;
				c.nw_data = SRC_D;
				c.pw_en   = 1'b1;
				c.pw_addr = SRC_POS;
				c.pw_data = SRC_D;
				c.fh_ld   = FH_NF;
				c.uw_en   = 1'b1;
				c.uw_val  = 1'b1;
				c.dw_en   = 1'b1;
				c.emit    = 1'b1;
				c.tgt     = S_IDLE;
			end
			S_DLA1: begin
				c.nw_en   = 1'b1;
				c.nw_addr = SRC_POS;
				c.nw_data = SRC_FARN;
				c.pw_en   = 1'b1;
				c.pw_addr = SRC_FARN;
				c.pw_data = SRC_POS;
				c.tgt     = S_DEL2;
			end
			S_DLB1: begin
				c.pw_en   = 1'b1;
				c.pw_addr = SRC_POS;
				c.pw_data = SRC_FARP;
				c.nw_en   = 1'b1;
				c.nw_addr = SRC_FARP;
				c.nw_data = SRC_POS;
				c.tgt     = S_DEL2;
			end
			S_DEL2: begin
				c.nw_en   = 1'b1;
				c.nw_addr = SRC_D;
				c.nw_data = SRC_FH;
				c.pw_en   = 1'b1;
				c.pw_addr = SRC_D;
				c.pw_data = SRC_FREL;
				c.tgt     = S_DEL3;
			end
			S_DEL3: begin
				c.pw_en   = 1'b1;
				c.pw_fhnz = 1'b1;
				c.pw_addr = SRC_FH;
				c.pw_data = SRC_D;
				c.fh_ld   = FH_D;
				c.uw_en   = 1'b1;
				c.uw_val  = 1'b0;
				c.emit    = 1'b1;
				c.tgt     = S_IDLE;
			end
			S_FIN: begin
				c.emit = 1'b1;
				c.tgt  = S_IDLE;
			end
			default: begin
				c.tgt = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/alle_seq.sv =====
// Step counter and control store sequencer of the array linked list engine.
// Depends on alle_pkg (step codes, control word, control store).
module alle_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_acc,
	input  logic            rsp_busy,
	input  alle_pkg::dpf_t  dpf,
	output alle_pkg::cw_t   cw,
	output logic            idle
);

	alle_pkg::step_t step_q;
	alle_pkg::step_t step_nx;
	alle_pkg::cw_t   rom;
	logic            fire;

	assign rom = alle_pkg::ucode(step_q);

	// a step that hands over a result waits while the output register is held
	assign fire = !(rom.emit && rsp_busy);

	always_comb begin
		step_nx = step_q;
		if (fire) begin
			unique case (rom.jmp)
				alle_pkg::J_GOTO: begin
					step_nx = rom.tgt;
				end
				alle_pkg::J_WAIT: begin
					if (req_acc) begin
						step_nx = rom.tgt;
					end
				end
				alle_pkg::J_DISPATCH: begin
					if (!dpf.ok) begin
						step_nx = alle_pkg::S_FIN;
					end else begin
						unique case (dpf.mode)
							alle_pkg::MD_INS_AFTER:  step_nx = alle_pkg::S_INA1;
							alle_pkg::MD_INS_BEFORE: step_nx = alle_pkg::S_INB1;
							alle_pkg::MD_DEL_AFTER:  step_nx = alle_pkg::S_DLA1;
							alle_pkg::MD_DEL_BEFORE: step_nx = alle_pkg::S_DLB1;
						endcase
					end
				end
				default: begin
					step_nx = alle_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cw   = fire ? rom : alle_pkg::CW_NOP;
		idle = (step_q == alle_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= alle_pkg::S_IDLE;
		end else begin
			step_q <= step_nx;
		end
	end

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cw.emit |=> step_q == alle_pkg::S_IDLE)
		else $error("sequencer did not return to idle after a result");

	a_chk_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cw.ld_chk |-> $past(idle))
		else $error("check step entered without a request");

endmodule

// ===== rtl/alle_dp.sv =====
// Datapath of the array linked list engine: link, use and data memories,
// free head, check logic and the post-reset init sweep. Depends on alle_pkg.
module alle_dp #(
	parameter int SLOT_COUNT = alle_pkg::DEF_SLOT_COUNT,
	parameter int DATA_WIDTH = alle_pkg::DEF_DATA_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_acc,
	input  alle_pkg::req_t  req,
	input  alle_pkg::cw_t   cw,
	output alle_pkg::dpf_t  dpf,
	output alle_pkg::rsp_t  res,
	output logic            clr_busy
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int XW = IW + alle_pkg::POS_W;
	localparam int VW = DATA_WIDTH + alle_pkg::VAL_W;
	localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);
	localparam logic [XW-1:0] SLOT_LIM = XW'(SLOT_COUNT);

	logic [IW-1:0]         nxt_mem [SLOT_COUNT];
	logic [IW-1:0]         prv_mem [SLOT_COUNT];
	logic                  use_mem [SLOT_COUNT];
	logic [DATA_WIDTH-1:0] dat_mem [SLOT_COUNT];

	alle_pkg::mode_t                   mode_q;
	logic [alle_pkg::POS_W-1:0]        pos_q;
	logic signed [alle_pkg::VAL_W-1:0] val_q;

	logic [IW-1:0] fh_q;
	logic [IW-1:0] d_q;
	logic [IW-1:0] lnk_q;
	logic [IW-1:0] nxa_q;
	logic [IW-1:0] pva_q;
	logic [IW-1:0] nxb_q;
	logic [IW-1:0] pvb_q;
	logic          use_q;
	logic [alle_pkg::POS_W-1:0] rslot_q;
	alle_pkg::status_t          rst_q;

	logic          clr_busy_q;
	logic [IW-1:0] clr_idx_q;

	logic [XW-1:0] pos_x;
	logic [XW-1:0] in_x;
	logic [XW-1:0] d_x;
	logic [VW-1:0] val_x;
	logic [IW-1:0] posi;
	logic [IW-1:0] in_idx;
	logic [IW-1:0] ra_n;
	logic [IW-1:0] ra_p;
	logic [IW-1:0] frel;
	logic [IW-1:0] lnk;
	logic [IW-1:0] dsel;
	logic          fh_nz;
	logic          ins;
	logic          on_prev;
	alle_pkg::status_t st;

	logic          nw_we;
	logic [IW-1:0] nw_a;
	logic [IW-1:0] nw_d;
	logic          pw_we;
	logic [IW-1:0] pw_a;
	logic [IW-1:0] pw_d;
	logic          uw_we;
	logic [IW-1:0] uw_a;
	logic          uw_d;

	function automatic logic [IW-1:0] pick(
		input alle_pkg::src_t s,
		input logic [IW-1:0]  pos,
		input logic [IW-1:0]  d,
		input logic [IW-1:0]  nb,
		input logic [IW-1:0]  fh,
		input logic [IW-1:0]  rel,
		input logic [IW-1:0]  farn,
		input logic [IW-1:0]  farp
	);
		logic [IW-1:0] r;
		unique case (s)
			alle_pkg::SRC_POS:  r = pos;
			alle_pkg::SRC_D:    r = d;
			alle_pkg::SRC_LNK:  r = nb;
			alle_pkg::SRC_FH:   r = fh;
			alle_pkg::SRC_FREL: r = rel;
			alle_pkg::SRC_FARN: r = farn;
			alle_pkg::SRC_FARP: r = farp;
			default:            r = '0;
		endcase
		return r;
	endfunction

	// position is a fixed-width field; widen before range check and indexing
	assign pos_x  = {{IW{1'b0}}, pos_q};
	assign in_x   = {{IW{1'b0}}, req.position};
	assign d_x    = {{alle_pkg::POS_W{1'b0}}, dsel};
	assign val_x  = {{DATA_WIDTH{1'b0}}, val_q};
	assign posi   = pos_x[IW-1:0];
	assign in_idx = in_x[IW-1:0];

	assign fh_nz  = (fh_q != '0);
	assign frel   = fh_nz ? pvb_q : '0;
	assign ra_n   = (cw.ra_sel == alle_pkg::RA_LINK) ? nxa_q : in_idx;
	assign ra_p   = (cw.ra_sel == alle_pkg::RA_LINK) ? pva_q : in_idx;

	always_comb begin
		ins     = (mode_q == alle_pkg::MD_INS_AFTER) || (mode_q == alle_pkg::MD_INS_BEFORE);
		on_prev = (mode_q == alle_pkg::MD_INS_BEFORE) || (mode_q == alle_pkg::MD_DEL_BEFORE);
		lnk     = on_prev ? pva_q : nxa_q;
		dsel    = ins ? fh_q : lnk;
		priority if (!(pos_x < SLOT_LIM) || !use_q) begin
			st = alle_pkg::ST_RANGE;
		end else if (ins && !fh_nz) begin
			st = alle_pkg::ST_FULL;
		end else if (!ins && (lnk == '0)) begin
			st = alle_pkg::ST_EMPTY;
		end else begin
			st = alle_pkg::ST_OK;
		end
		dpf.ok   = (st == alle_pkg::ST_OK);
		dpf.mode = mode_q;
	end

	// write ports: init sweep after reset, else the control word
	always_comb begin
		if (clr_busy_q) begin
			nw_we = 1'b1;
			nw_a  = clr_idx_q;
			nw_d  = ((clr_idx_q == '0) || (clr_idx_q == LAST)) ? '0 : clr_idx_q + IW'(1);
			pw_we = 1'b1;
			pw_a  = clr_idx_q;
			pw_d  = (clr_idx_q == '0) ? '0 : clr_idx_q - IW'(1);
			uw_we = 1'b1;
			uw_a  = clr_idx_q;
			uw_d  = (clr_idx_q == '0);
		end else begin
			nw_we = cw.nw_en;
			nw_a  = pick(cw.nw_addr, posi, d_q, lnk_q, fh_q, frel, nxa_q, pva_q);
			nw_d  = pick(cw.nw_data, posi, d_q, lnk_q, fh_q, frel, nxa_q, pva_q);
			pw_we = cw.pw_en && (!cw.pw_fhnz || fh_nz);
			pw_a  = pick(cw.pw_addr, posi, d_q, lnk_q, fh_q, frel, nxa_q, pva_q);
			pw_d  = pick(cw.pw_data, posi, d_q, lnk_q, fh_q, frel, nxa_q, pva_q);
			uw_we = cw.uw_en;
			uw_a  = d_q;
			uw_d  = cw.uw_val;
		end
	end

	always_ff @(posedge clk) begin
		if (nw_we) begin
			nxt_mem[nw_a] <= nw_d;
		end
		if (cw.rda_en) begin
			nxa_q <= nxt_mem[ra_n];
		end
		if (cw.rdb_en) begin
			nxb_q <= nxt_mem[fh_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pw_we) begin
			prv_mem[pw_a] <= pw_d;
		end
		if (cw.rda_en) begin
			pva_q <= prv_mem[ra_p];
		end
		if (cw.rdb_en) begin
			pvb_q <= prv_mem[fh_q];
		end
	end

	always_ff @(posedge clk) begin
		if (uw_we) begin
			use_mem[uw_a] <= uw_d;
		end
		if (cw.rda_en) begin
			use_q <= use_mem[ra_p];
		end
	end

	always_ff @(posedge clk) begin
		if (cw.dw_en) begin
			dat_mem[d_q] <= val_x[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q <= req.mode;
			pos_q  <= req.position;
			val_q  <= req.item_value;
		end
		if (cw.ld_chk) begin
			d_q     <= dsel;
			lnk_q   <= lnk;
			rslot_q <= dpf.ok ? d_x[alle_pkg::POS_W-1:0] : '0;
			rst_q   <= st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q <= IW'(1);
		end else begin
			unique case (cw.fh_ld)
				alle_pkg::FH_KEEP: fh_q <= fh_q;
				alle_pkg::FH_NF:   fh_q <= nxb_q;
				alle_pkg::FH_D:    fh_q <= d_q;
				default:           fh_q <= fh_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == LAST) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + IW'(1);
			end
		end
	end

	assign clr_busy = clr_busy_q;
	assign res      = '{slot: rslot_q, status: rst_q};

	a_fh_prev_nz: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q && cw.pw_fhnz && pw_we |-> pw_a != '0)
		else $error("free list prev update hit the sentinel");

	a_sweep_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_idx_q) == LAST)
		else $error("init sweep ended early");

	a_ok_slot_nz: assert property (@(posedge clk) disable iff (!arst_n)
		cw.ld_chk && dpf.ok |=> d_q != '0)
		else $error("accepted operation touches the sentinel");

endmodule

// ===== rtl/array_linked_list_engine_unit.sv =====
// Array linked list engine top level: handshakes and result register.
// Depends on alle_pkg, alle_seq and alle_dp.
//
// Keeps a doubly linked list of SLOT_COUNT slots (slot 0 is the head/tail
// sentinel) with a free list chained through the next links. Each request
// inserts after/before or deletes after/before a position and returns one
// response with the touched slot and a status. After reset the link memories
// are initialized by a sweep over every slot, during which req_stall stays
// high. An accepted request then runs the check step and then INA1 and INA2
// or INB1 and INB2 for inserts, DLA1 or DLB1 then DEL2 and DEL3 for deletes,
// or FIN when flagged, and returns to idle before the next accept; the
// microcode program spends one step per dependent read or write on the single
// write port of each link memory. A finished response sits in an output
// register, so the next request is taken while it waits.
module array_linked_list_engine_unit #(
	parameter int SLOT_COUNT = alle_pkg::DEF_SLOT_COUNT,
	parameter int DATA_WIDTH = alle_pkg::DEF_DATA_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  alle_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output alle_pkg::rsp_t  rsp
);

	alle_pkg::cw_t  cw;
	alle_pkg::dpf_t dpf;
	alle_pkg::rsp_t res;
	alle_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic           req_acc;
	logic           rsp_busy;
	logic           idle;
	logic           clr_busy;

	assign req_stall = !idle || clr_busy;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_busy  = rsp_valid_q && rsp_stall;

	alle_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_acc  (req_acc),
		.rsp_busy (rsp_busy),
		.dpf      (dpf),
		.cw       (cw),
		.idle     (idle)
	);

	alle_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_acc  (req_acc),
		.req      (req),
		.cw       (cw),
		.dpf      (dpf),
		.res      (res),
		.clr_busy (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cw.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.emit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cw.emit |-> !rsp_busy)
		else $error("response overwritten before transfer");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for array_linked_list_engine_unit: a queue-fed driver, a monitor and
// a linked list predictor kept here. Depends on alle_pkg and the engine RTL.
module testbench;

	localparam int SLOTS = alle_pkg::DEF_SLOT_COUNT;
	localparam int PW = alle_pkg::POS_W;
	// two copies of the list: one steers stimulus, one predicts at accept time
	localparam int GEN = 0;
	localparam int CHK = 1;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	alle_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	alle_pkg::rsp_t rsp;

	logic [PW-1:0] lnk_next [2][SLOTS];
	logic [PW-1:0] lnk_prev [2][SLOTS];
	bit slot_live [2][SLOTS];
	logic [PW-1:0] free_top [2];

	alle_pkg::req_t pending_req [$];
	alle_pkg::rsp_t slot_expect [$];
	int live_slots [$];
	int n_made = 0;
	int n_sent = 0;
	int n_rsp = 0;
	int n_fail = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit quiet = 1'b0;

	array_linked_list_engine_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	function automatic void list_clear(int m);
		int i;
		for (i = 0; i < SLOTS; i++) begin
			lnk_next[m][i] = (i == 0 || i == SLOTS - 1) ? '0 : PW'(i + 1);
			lnk_prev[m][i] = (i == 0) ? '0 : PW'(i - 1);
			slot_live[m][i] = (i == 0);
		end
		free_top[m] = PW'(1);
	endfunction

	// one list operation on copy m; returns the response the engine must give
	function automatic alle_pkg::rsp_t list_apply(int m, alle_pkg::req_t r);
		alle_pkg::rsp_t o;
		logic [PW-1:0] p, f, d, a, b;
		o.slot = '0;
		o.status = alle_pkg::ST_OK;
		p = r.position;
		if (!slot_live[m][p]) begin
			o.status = alle_pkg::ST_RANGE;
		end else if (r.mode == alle_pkg::MD_INS_AFTER || r.mode == alle_pkg::MD_INS_BEFORE) begin
			if (free_top[m] == 0) begin
				o.status = alle_pkg::ST_FULL;
			end else begin
				f = free_top[m];
				free_top[m] = lnk_next[m][f];
				slot_live[m][f] = 1'b1;
				if (r.mode == alle_pkg::MD_INS_AFTER) begin
					a = lnk_next[m][p];
					lnk_next[m][f] = a;
					lnk_prev[m][f] = p;
					lnk_prev[m][a] = f;
					lnk_next[m][p] = f;
				end else begin
					b = lnk_prev[m][p];
					lnk_prev[m][f] = b;
					lnk_next[m][f] = p;
					lnk_next[m][b] = f;
					lnk_prev[m][p] = f;
				end
				o.slot = f;
			end
		end else begin
			d = (r.mode == alle_pkg::MD_DEL_AFTER) ? lnk_next[m][p] : lnk_prev[m][p];
			if (d == 0) begin
				o.status = alle_pkg::ST_EMPTY;
			end else begin
				if (r.mode == alle_pkg::MD_DEL_AFTER) begin
					a = lnk_next[m][d];
					lnk_next[m][p] = a;
					lnk_prev[m][a] = p;
				end else begin
					b = lnk_prev[m][d];
					lnk_prev[m][p] = b;
					lnk_next[m][b] = p;
				end
				// push onto the free list; a freed slot in a full list stands alone
				if (free_top[m] != 0) begin
					lnk_prev[m][d] = lnk_prev[m][free_top[m]];
					lnk_prev[m][free_top[m]] = d;
				end else begin
					lnk_prev[m][d] = '0;
				end
				lnk_next[m][d] = free_top[m];
				free_top[m] = d;
				slot_live[m][d] = 1'b0;
				o.slot = d;
			end
		end
		return o;
	endfunction

	task automatic push_op(alle_pkg::mode_t md, logic [PW-1:0] pos,
		logic signed [alle_pkg::VAL_W-1:0] v);
		alle_pkg::req_t r;
		alle_pkg::rsp_t o;
		int k;
		r.mode = md;
		r.position = pos;
		r.item_value = v;
		o = list_apply(GEN, r);
		if (o.status == alle_pkg::ST_OK) begin
			if (md == alle_pkg::MD_INS_AFTER || md == alle_pkg::MD_INS_BEFORE) begin
				live_slots.push_back(o.slot);
			end else begin
				for (k = 0; k < live_slots.size(); k++) begin
					if (live_slots[k] == o.slot) begin
						live_slots.delete(k);
						break;
					end
				end
			end
		end
		pending_req.push_back(r);
		n_made++;
	endtask

	function automatic int any_live();
		return live_slots[$urandom_range(0, live_slots.size() - 1)];
	endfunction

	// mostly positions in the list, some noise; inserts favored below fill_to
	task automatic mix_ops(int n, int fill_to);
		int i;
		int ins_pct;
		alle_pkg::mode_t md;
		logic [PW-1:0] pos;
		for (i = 0; i < n; i++) begin
			ins_pct = (live_slots.size() < fill_to) ? 65 : 35;
			if ($urandom_range(0, 99) < ins_pct)
				md = alle_pkg::mode_t'($urandom_range(0, 1));
			else
				md = alle_pkg::mode_t'($urandom_range(2, 3));
			if ($urandom_range(0, 99) < 8)
				pos = PW'($urandom_range(0, SLOTS - 1));
			else
				pos = PW'(any_live());
			push_op(md, pos, $urandom);
		end
	endtask

	task automatic wait_drain();
		while (n_sent != n_made || slot_expect.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left = 0;
		end else begin
			if (req_valid && !req_stall) begin
				slot_expect.push_back(list_apply(CHK, req));
				n_sent++;
			end
			// a stalled transfer keeps its payload
			if (!(req_valid && req_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_req.size() != 0 && (quiet || $urandom_range(0, 7) != 0)) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
					if (pending_req.size() != 0)
						gap_left = $urandom_range(0, 2);
				end
			end
		end
	end

	// monitor and result-side stall
	always @(posedge clk or negedge arst_n) begin
		alle_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				n_rsp++;
				if (slot_expect.size() == 0) begin
					n_fail++;
					$error("unexpected transfer: slot %0d status %s", rsp.slot, rsp.status.name());
				end else begin
					want = slot_expect.pop_front();
					if (rsp.slot !== want.slot) begin
						n_fail++;
						$error("slot: expected %0d, actual %0d", want.slot, rsp.slot);
					end
					if (rsp.status !== want.status) begin
						n_fail++;
						$error("status: expected %s, actual %s", want.status.name(),
							rsp.status.name());
					end
				end
				// long hold-off so the engine backs up into its input
				if (n_rsp == 60)
					hold_left = 50;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 2);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		list_clear(GEN);
		list_clear(CHK);
		live_slots.push_back(0);

		// empty list, free positions, value extremes, insert-before linkage
		push_op(alle_pkg::MD_DEL_AFTER, 0, 0);
		push_op(alle_pkg::MD_DEL_BEFORE, 0, 0);
		push_op(alle_pkg::MD_INS_AFTER, 5, 1);
		push_op(alle_pkg::MD_INS_BEFORE, PW'(SLOTS - 1), 2);
		push_op(alle_pkg::MD_DEL_AFTER, 1, 3);
		push_op(alle_pkg::MD_INS_AFTER, 0, 32'sh7fffffff);
		push_op(alle_pkg::MD_INS_BEFORE, 0, 32'sh80000000);
		push_op(alle_pkg::MD_INS_BEFORE, 1, 0);
		push_op(alle_pkg::MD_INS_AFTER, 2, -1);
		push_op(alle_pkg::MD_DEL_BEFORE, 3, 0);
		push_op(alle_pkg::MD_DEL_AFTER, 4, 0);
		push_op(alle_pkg::MD_DEL_AFTER, 0, 0);
		push_op(alle_pkg::MD_DEL_BEFORE, 0, 0);
		push_op(alle_pkg::MD_DEL_AFTER, 3, 0);
		push_op(alle_pkg::MD_INS_BEFORE, 2, 32'sh55555555);
		push_op(alle_pkg::MD_INS_AFTER, 2, 32'shaaaaaaaa);
		push_op(alle_pkg::MD_DEL_BEFORE, 2, 0);
		push_op(alle_pkg::MD_DEL_AFTER, 2, 0);
		// sender holds back until every result is in
		wait_drain();

		mix_ops(60, 40);

		// fill to the last slot, then full inserts and deletes from a full list
		while (free_top[GEN] != 0)
			push_op(alle_pkg::mode_t'($urandom_range(0, 1)), PW'(any_live()), $urandom);
		push_op(alle_pkg::MD_INS_AFTER, PW'(SLOTS - 1), $urandom);
		push_op(alle_pkg::MD_INS_BEFORE, 0, $urandom);
		push_op(alle_pkg::MD_DEL_AFTER, 0, 0);
		push_op(alle_pkg::MD_INS_BEFORE, 0, $urandom);
		push_op(alle_pkg::MD_INS_AFTER, PW'(any_live()), $urandom);
		push_op(alle_pkg::MD_DEL_BEFORE, 0, 0);
		push_op(alle_pkg::MD_DEL_AFTER, PW'(SLOTS - 1), 0);
		push_op(alle_pkg::MD_DEL_BEFORE, PW'(SLOTS - 1), 0);
		push_op(alle_pkg::MD_INS_AFTER, PW'(SLOTS - 1), $urandom);
		mix_ops(40, SLOTS);
		wait_drain();

		quiet = 1'b1;
		mix_ops(50, 60);
		wait_drain();
		repeat (40) @(posedge clk);

		if (n_fail == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
